/* src/horspool_substring_search_core_macros.svh */
// Assertion macros for the Horspool substring search core.
`ifndef HORSPOOL_SUBSTRING_SEARCH_CORE_MACROS_SVH
`define HORSPOOL_SUBSTRING_SEARCH_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define HSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hss assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define HSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hss assertion failed");
`else
`define HSS_ASSERT_NOW(label, ante, cons)
`define HSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/hss_pkg.sv */
// Shared constants, payload types and control structs of the Horspool search core.
package hss_pkg;

	localparam int TEXT_DEPTH    = 4096;
	localparam int PATTERN_MAX   = 16;
	localparam int ALPHABET_SIZE = 256;

	localparam int BYTE_W     = $clog2(ALPHABET_SIZE);
	localparam int ADDR_W     = $clog2(TEXT_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int PLEN_W     = $clog2(PATTERN_MAX + 1);
	localparam int KIDX_W     = $clog2(PATTERN_MAX);
	localparam int PLEN_CFG_W = 5;
	localparam int OFFSET_W   = 12;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int PAT_W      = 2 * CFG_W;

	// Printable range: tail bytes outside it take a full-length jump
	localparam logic [BYTE_W-1:0] PRINT_LO = 8'h21;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7f;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
		logic                overflowed;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic store;    // write one text byte
		logic init;     // restart window at offset zero
		logic rd_tail;  // read window's last byte
		logic rd_next;  // read next byte of the window
		logic compare;  // read data is valid this cycle
		logic advance;  // jump to next window
		logic set_hit;  // record a match
		logic clr_hit;  // record no match
		logic deliver;  // load output register and clear text state
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic window_fits;
		logic byte_eq;
		logic last_cmp;
	} sts_t;

endpackage

/* src/hss_datapath.sv */
// Datapath: configuration registers, text memory, window position and result register.
module hss_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hss_pkg::CFG_W-1:0]      cfg_wdata,
	input  hss_pkg::in_item_t              in_item,
	input  hss_pkg::cmd_t                  cmd,
	output hss_pkg::sts_t                  sts,
	output hss_pkg::out_item_t             out_item
);

	logic [hss_pkg::PLEN_CFG_W-1:0] plen_cfg_q;
	logic [hss_pkg::PAT_W-1:0]      pat_q;
	logic [hss_pkg::PLEN_W-1:0]     plen;

	logic [hss_pkg::BYTE_W-1:0]     text_mem [hss_pkg::TEXT_DEPTH];
	logic [hss_pkg::BYTE_W-1:0]     rdata_q;
	logic [hss_pkg::CNT_W-1:0]      count_q;
	logic                           ovf_q;
	logic [hss_pkg::CNT_W-1:0]      pos_q;
	logic [hss_pkg::KIDX_W-1:0]     j_q;
	logic [hss_pkg::BYTE_W-1:0]     tail_q;
	logic                           hit_q;
	hss_pkg::out_item_t             out_q;

	logic                           full;
	logic [hss_pkg::CNT_W-1:0]      rd_addr;
	logic [hss_pkg::KIDX_W-1:0]     pat_idx;
	logic [hss_pkg::BYTE_W-1:0]     pat_byte;
	logic [hss_pkg::CNT_W:0]        window_end;

	// Horspool jump for a tail byte; last occurrence in the pattern head wins
	function automatic logic [hss_pkg::PLEN_W-1:0] skip_for(
		input logic [hss_pkg::BYTE_W-1:0] c,
		input logic [hss_pkg::PLEN_W-1:0] len,
		input logic [hss_pkg::PAT_W-1:0]  pat
	);
		logic [hss_pkg::PLEN_W-1:0] s;
		s = len;
		if (c >= hss_pkg::PRINT_LO && c <= hss_pkg::PRINT_HI) begin
			for (int k = 0; k < hss_pkg::PATTERN_MAX - 1; k++) begin
				if (hss_pkg::PLEN_W'(k + 1) < len &&
						pat[k*hss_pkg::BYTE_W +: hss_pkg::BYTE_W] == c) begin
					s = len - hss_pkg::PLEN_W'(k + 1);
				end
			end
		end
		return s;
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_cfg_q <= hss_pkg::PLEN_CFG_W'(1);
			pat_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hss_pkg::REG_PATTERN_LENGTH:
					plen_cfg_q <= cfg_wdata[hss_pkg::PLEN_CFG_W-1:0];
				hss_pkg::REG_PATTERN_LOW:  pat_q[hss_pkg::CFG_W-1:0] <= cfg_wdata;
				hss_pkg::REG_PATTERN_HIGH: pat_q[hss_pkg::PAT_W-1:hss_pkg::CFG_W] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp pattern length into 1..PATTERN_MAX
	always_comb begin
		if (plen_cfg_q == '0) begin
			plen = hss_pkg::PLEN_W'(1);
		end else if (plen_cfg_q > hss_pkg::PLEN_CFG_W'(hss_pkg::PATTERN_MAX)) begin
			plen = hss_pkg::PLEN_W'(hss_pkg::PATTERN_MAX);
		end else begin
			plen = hss_pkg::PLEN_W'(plen_cfg_q);
		end
	end

	assign full = (count_q == hss_pkg::CNT_W'(hss_pkg::TEXT_DEPTH));

	// Read address: tail first, then bytes from the window start onwards
	always_comb begin
		if (cmd.rd_tail) begin
			rd_addr = pos_q + hss_pkg::CNT_W'(plen) - hss_pkg::CNT_W'(1);
		end else begin
			rd_addr = pos_q + hss_pkg::CNT_W'(j_q);
		end
	end

	// Text memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store && !full) begin
			text_mem[count_q[hss_pkg::ADDR_W-1:0]] <= in_item.text_byte;
		end
		if (cmd.rd_tail || cmd.rd_next) begin
			rdata_q <= text_mem[rd_addr[hss_pkg::ADDR_W-1:0]];
		end
	end

	// Fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.deliver) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.store) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + hss_pkg::CNT_W'(1);
			end
		end
	end

	// Window position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.init) begin
			pos_q <= '0;
		end else if (cmd.advance) begin
			pos_q <= pos_q + hss_pkg::CNT_W'(skip_for(tail_q, plen, pat_q));
		end
	end

	// Compare step index, captured tail byte, match flag and output register
	always_ff @(posedge clk) begin
		if (cmd.rd_tail) begin
			j_q <= '0;
		end else if (cmd.rd_next) begin
			j_q <= j_q + hss_pkg::KIDX_W'(1);
		end
		if (cmd.compare && j_q == '0) begin
			tail_q <= rdata_q;
		end
		if (cmd.set_hit) begin
			hit_q <= 1'b1;
		end else if (cmd.clr_hit) begin
			hit_q <= 1'b0;
		end
		if (cmd.deliver) begin
			out_q.found        <= hit_q;
			out_q.match_offset <= hit_q ? hss_pkg::OFFSET_W'(pos_q) : '0;
			out_q.overflowed   <= ovf_q;
		end
	end

	// Pattern byte for the current step: last byte first, then from byte 0
	assign pat_idx  = (j_q == '0) ? hss_pkg::KIDX_W'(plen - hss_pkg::PLEN_W'(1))
		: j_q - hss_pkg::KIDX_W'(1);
	assign pat_byte = pat_q[{pat_idx, 3'b000} +: hss_pkg::BYTE_W];

	assign window_end = {1'b0, pos_q} + (hss_pkg::CNT_W + 1)'(plen);

	assign sts.window_fits = (window_end <= {1'b0, count_q});
	assign sts.byte_eq     = (rdata_q == pat_byte);
	assign sts.last_cmp    = (hss_pkg::PLEN_W'(j_q) == plen - hss_pkg::PLEN_W'(1));

	assign out_item = out_q;

endmodule

/* src/hss_ctrl.sv */
// Controller: sequences text loading, window checks, jumps and result delivery.
module hss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  hss_pkg::sts_t sts,
	output hss_pkg::cmd_t cmd
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.store = in_valid;
				if (in_valid && in_last) begin
					cmd.init = 1'b1;
					state_d  = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (sts.window_fits) begin
					cmd.rd_tail = 1'b1;
					state_d     = S_CMP;
				end else begin
					cmd.clr_hit = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				if (!sts.byte_eq) begin
					state_d = S_SHIFT;
				end else if (sts.last_cmp) begin
					cmd.set_hit = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.advance = 1'b1;
				state_d     = S_ISSUE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.deliver = 1'b1;
					state_d     = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = out_valid_q;

endmodule

/* src/horspool_substring_search_core.sv */
// Top level of the Horspool substring search core.
// Text bytes are taken one per cycle while a text is being loaded, into a TEXT_DEPTH-byte
// buffer; bytes beyond it are dropped and flagged. The byte marked last starts a search
// for the configured pattern (1 to 16 bytes). A window is checked by reading its last
// byte, then comparing bytes one at a time (last byte, first byte, then the middle bytes
// in order) up to the first mismatch and, unless it matches, jumping, all in turn as set
// by the single read port of the text memory; a text shorter than the pattern gives no
// match without any read. The result sits in an output register, and loading of the
// next text starts while it waits to be taken. Input is not taken during a search. The
// pattern registers must not be written while a text is being loaded or searched.
`include "horspool_substring_search_core_macros.svh"

module horspool_substring_search_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hss_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  hss_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output hss_pkg::out_item_t             out_item
);

	hss_pkg::cmd_t cmd;
	hss_pkg::sts_t sts;

	// Controller
	hss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_item.last_byte),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	hss_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

	// A delivered result shows up as valid on the next cycle
	`HSS_ASSERT_NEXT(a_deliver_valid, cmd.deliver, out_valid)
	// Tail reads only happen for windows that lie inside the stored text
	`HSS_ASSERT_NOW(a_tail_in_range, cmd.rd_tail, sts.window_fits)
	// A transfer of the last byte stops further input until the search ends
	`HSS_ASSERT_NEXT(a_last_stops_input, in_valid && in_ready && in_item.last_byte, !in_ready)

endmodule
